// File: design/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants for the pointer gesture recognizer: field widths,
// register indexes and reset values, stroke directions, action codes.
// ----------------------------------------------------------------------------
package pgr_pkg;

  // Coordinate width default and fixed stroke list depth
  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_STROKES    = 3;
  localparam int CNT_W          = 2;

  // Result fields
  localparam int ACTION_W = 4;
  localparam int TOTAL_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int THR_W      = 10;
  localparam int STOP_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 2'd2;

  localparam logic              EN_RST   = 1'b1;
  localparam logic [THR_W-1:0]  THR_RST  = 10'd16;
  localparam logic [STOP_W-1:0] STOP_RST = 8'd2;

  // Distance arithmetic: components clip at 2048, turn vectors kept at 14 bits
  localparam int CLIP_W   = 12;
  localparam int CLIP_MAX = 2048;
  localparam int SUM_W    = 24;
  localparam int TURN_W   = 14;

  // Shared multiplier
  localparam int MUL_W  = 30;
  localparam int PROD_W = 60;
  localparam int DOT_W  = 31;

  // Stroke directions
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_NONE        = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_BACK        = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_FORWARD     = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_RELOAD      = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_PARENT      = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_NEW_WINDOW  = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_DUPLICATE   = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE_SIZE = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_ICONIFY     = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_CLOSE       = 4'd9;

  // Stroke list control from the sequencer
  typedef struct packed {
    logic clear;
    logic rec;
    dir_t dir;
  } strk_ctl_t;

endpackage

// File: design/pgr_mul.sv
// ----------------------------------------------------------------------------
// pgr_mul
// Shared unsigned multiplier with a registered product; one issue per cycle.
// ----------------------------------------------------------------------------
module pgr_mul (
  input  logic                       clk,
  input  logic [pgr_pkg::MUL_W-1:0]  mul_a,
  input  logic [pgr_pkg::MUL_W-1:0]  mul_b,
  output logic [pgr_pkg::PROD_W-1:0] prod_r
);
  import pgr_pkg::*;

  // the product is registered and lands in the cycle after issue
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

// File: design/pgr_strokes.sv
// ----------------------------------------------------------------------------
// pgr_strokes
// Stroke list with merge of repeated directions, stroke count and the
// decode of the finished list into an action code.
// ----------------------------------------------------------------------------
module pgr_strokes (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pgr_pkg::strk_ctl_t           ctl,
  output logic [pgr_pkg::CNT_W-1:0]    count,
  output logic                         full,
  output logic [pgr_pkg::ACTION_W-1:0] action
);
  import pgr_pkg::*;

  dir_t             list_r [MAX_STROKES];
  logic [CNT_W-1:0] count_r;
  dir_t             last;
  logic             do_rec;

  // merge a direction equal to the last one recorded
  assign last   = list_r[CNT_W'(count_r - 1'b1)];
  assign do_rec = ctl.rec && !ctl.clear && (count_r < CNT_W'(MAX_STROKES)) &&
                  ((count_r == '0) || (last != ctl.dir));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (do_rec) begin
      count_r <= count_r + 1'b1;
    end
  end

  // list entries carry no reset; only entries below the count are read
  always_ff @(posedge clk) begin
    if (do_rec) begin
      list_r[count_r] <= ctl.dir;
    end
  end

  assign count = count_r;
  assign full  = (count_r == CNT_W'(MAX_STROKES));

  // action decode
  always_comb begin
    action = ACT_NONE;
    case (count_r)
      2'd1: begin
        case (list_r[0])
          DIR_LEFT:  action = ACT_BACK;
          DIR_RIGHT: action = ACT_FORWARD;
          DIR_DOWN:  action = ACT_NEW_WINDOW;
          default:   action = ACT_NONE;
        endcase
      end
      2'd2: begin
        case (list_r[0])
          DIR_UP: begin
            case (list_r[1])
              DIR_DOWN:  action = ACT_RELOAD;
              DIR_RIGHT: action = ACT_TOGGLE_SIZE;
              DIR_LEFT:  action = ACT_PARENT;
              default:   action = ACT_NONE;
            endcase
          end
          DIR_DOWN: begin
            case (list_r[1])
              DIR_LEFT:  action = ACT_ICONIFY;
              DIR_UP:    action = ACT_DUPLICATE;
              DIR_RIGHT: action = ACT_CLOSE;
              default:   action = ACT_NONE;
            endcase
          end
          default: action = ACT_NONE;
        endcase
      end
      2'd3: begin
        if (list_r[0] == DIR_RIGHT && list_r[1] == DIR_LEFT && list_r[2] == DIR_RIGHT) begin
          action = ACT_CLOSE;
        end
      end
      default: action = ACT_NONE;
    endcase
  end

endmodule

// File: design/pointer_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// pointer_gesture_recognizer
// Stroke gesture recognizer over pointer samples; one shared multiplier under
// a small sequencer does all squared-distance and turn-angle arithmetic.
// ----------------------------------------------------------------------------
// One sample is handled at a time; in_stall is high from the cycle after
// acceptance until the sequencer is back in idle. A sample while idle goes
// through S_EVAL only; a held or in-gesture sample that finds gestures
// disabled goes through S_EVAL and S_EMIT0; a sample while seeking or an
// ordinary stroking sample goes through S_EVAL, S_SQ0 to S_SQ3 and S_FIN; a
// stroking sample that needs the turn test adds S_TURN0, S_SHR (which halves
// the current offset and the reference vector until each fits in 14 bits)
// and S_D0 to S_D8. Every square and product goes through the single shared
// multiplier, one per cycle. A result waits in an output register; a sample
// that ends a gesture holds in its last state only while an earlier result
// is still stalled.
// ----------------------------------------------------------------------------
module pointer_gesture_recognizer #(
  parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_pointer_x,
  input  logic signed [COORD_BITS-1:0]     in_pointer_y,
  input  logic                             in_button_held,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pgr_pkg::ACTION_W-1:0]     out_gesture_action,
  output logic [pgr_pkg::TOTAL_W-1:0]      out_stroke_total,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pgr_pkg::*;

  localparam int DW = COORD_BITS + 1;               // coordinate differences
  localparam int XW = DW + CLIP_W;                  // compare against clip limit
  localparam int CW = (DW > THR_W) ? DW + 2 : THR_W + 2;
  localparam int EW = PROD_W + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_EVAL, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_TURN0, S_SHR,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_FIN, S_EMIT0
  } state_t;

  // magnitude of a difference
  function automatic logic [DW-1:0] f_mag(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // magnitude clipped at the distance limit
  function automatic logic [CLIP_W-1:0] f_clip(input logic [DW-1:0] m);
    return (XW'(m) > XW'(CLIP_MAX)) ? CLIP_W'(CLIP_MAX) : CLIP_W'(m);
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic                en_r, en_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [STOP_W-1:0]   stop_r, stop_nxt;
  logic                active_r, active_nxt;
  logic                stroking_r, stroking_nxt;
  logic                out_valid_r, out_valid_nxt;

  // sample and gesture registers
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic                         held_r, held_nxt;
  logic signed [COORD_BITS-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [DW-1:0]         ref_dx_r, ref_dx_nxt, ref_dy_r, ref_dy_nxt;

  // working registers
  logic signed [DW-1:0] ox_r, ox_nxt, oy_r, oy_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [DW-1:0]        umx_r, umx_nxt, umy_r, umy_nxt, vmx_r, vmx_nxt, vmy_r, vmy_nxt;
  logic                 sux_r, sux_nxt, suy_r, suy_nxt, svx_r, svx_nxt, svy_r, svy_nxt;
  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [MUL_W-1:0]     nu_r, nu_nxt, nv_r, nv_nxt;
  logic [PROD_W-1:0]    sq_r, sq_nxt;
  logic [ACTION_W-1:0]  act_r, act_nxt;
  logic [TOTAL_W-1:0]   tot_r, tot_nxt;

  // shared multiplier and stroke list
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    prod_r;
  strk_ctl_t            strk_ctl;
  logic [CNT_W-1:0]     strk_count;
  logic                 strk_full;
  logic [ACTION_W-1:0]  strk_action;

  // derived values
  logic signed [DW-1:0]    sel_x, sel_y;
  logic [THR_W-1:0]        lim;
  logic [DW-1:0]           ax, ay;
  logic [CW-1:0]           ax4, ay4, thr3;
  logic [TURN_W-1:0]       ux, uy, vx, vy;
  logic                    u_big, v_big, out_busy;
  logic signed [DOT_W-1:0] pterm;

  pgr_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  pgr_strokes u_strokes (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (strk_ctl),
    .count  (strk_count),
    .full   (strk_full),
    .action (strk_action)
  );

  // operand selection for the distance test
  assign sel_x = stroking_r ? mx_r : ox_r;
  assign sel_y = stroking_r ? my_r : oy_r;
  assign lim   = stroking_r ? THR_W'(stop_r) : thr_r;

  // dominant axis test against three quarters of the threshold
  assign ax   = f_mag(ox_r);
  assign ay   = f_mag(oy_r);
  assign ax4  = CW'(ax) << 2;
  assign ay4  = CW'(ay) << 2;
  assign thr3 = CW'(thr_r) + (CW'(thr_r) << 1);

  // turn vectors, shrunk to 14-bit magnitudes
  assign ux    = TURN_W'(umx_r);
  assign uy    = TURN_W'(umy_r);
  assign vx    = TURN_W'(vmx_r);
  assign vy    = TURN_W'(vmy_r);
  assign u_big = ((umx_r >> TURN_W) != '0) || ((umy_r >> TURN_W) != '0);
  assign v_big = ((vmx_r >> TURN_W) != '0) || ((vmy_r >> TURN_W) != '0);
  assign pterm = signed'(DOT_W'(prod_r));

  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid          = out_valid_r;
  assign out_gesture_action = act_r;
  assign out_stroke_total   = tot_r;

  // multiplier operand mux
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ0: begin
        mul_a = MUL_W'(f_clip(f_mag(sel_x)));
        mul_b = mul_a;
      end
      S_SQ1: begin
        mul_a = MUL_W'(f_clip(f_mag(sel_y)));
        mul_b = mul_a;
      end
      S_SQ2: begin
        mul_a = MUL_W'(lim);
        mul_b = mul_a;
      end
      S_D0: begin
        mul_a = MUL_W'(ux);
        mul_b = MUL_W'(vx);
      end
      S_D1: begin
        mul_a = MUL_W'(uy);
        mul_b = MUL_W'(vy);
      end
      S_D2: begin
        mul_a = MUL_W'(ux);
        mul_b = MUL_W'(ux);
      end
      S_D3: begin
        mul_a = MUL_W'(uy);
        mul_b = MUL_W'(uy);
      end
      S_D4: begin
        mul_a = MUL_W'(vx);
        mul_b = MUL_W'(vx);
      end
      S_D5: begin
        mul_a = MUL_W'(vy);
        mul_b = MUL_W'(vy);
      end
      S_D6: begin
        mul_a = dot_r[MUL_W-1:0];
        mul_b = dot_r[MUL_W-1:0];
      end
      S_D7: begin
        mul_a = nu_r;
        mul_b = nv_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    en_nxt        = en_r;
    thr_nxt       = thr_r;
    stop_nxt      = stop_r;
    active_nxt    = active_r;
    stroking_nxt  = stroking_r;
    out_valid_nxt = out_busy;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    held_nxt      = held_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    ref_dx_nxt    = ref_dx_r;
    ref_dy_nxt    = ref_dy_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    sum_nxt       = sum_r;
    umx_nxt       = umx_r;
    umy_nxt       = umy_r;
    vmx_nxt       = vmx_r;
    vmy_nxt       = vmy_r;
    sux_nxt       = sux_r;
    suy_nxt       = suy_r;
    svx_nxt       = svx_r;
    svy_nxt       = svy_r;
    dot_nxt       = dot_r;
    nu_nxt        = nu_r;
    nv_nxt        = nv_r;
    sq_nxt        = sq_r;
    act_nxt       = act_r;
    tot_nxt       = tot_r;
    strk_ctl      = '{clear: 1'b0, rec: 1'b0, dir: DIR_LEFT};

    // configuration transaction
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:    en_nxt   = cfg_data[0];
        CFG_THRESHOLD: thr_nxt  = cfg_data[THR_W-1:0];
        CFG_STOP:      stop_nxt = cfg_data[STOP_W-1:0];
        default:       en_nxt   = en_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cx_nxt    = in_pointer_x;
          cy_nxt    = in_pointer_y;
          held_nxt  = in_button_held;
          state_nxt = S_EVAL;
        end
      end

      // idle handling, or offsets for an active gesture
      S_EVAL: begin
        if (!active_r) begin
          if (!held_r) begin
            state_nxt = S_IDLE;
          end else if (!en_r) begin
            state_nxt = S_EMIT0;
          end else begin
            active_nxt     = 1'b1;
            stroking_nxt   = 1'b0;
            org_x_nxt      = cx_r;
            org_y_nxt      = cy_r;
            prev_x_nxt     = cx_r;
            prev_y_nxt     = cy_r;
            ref_dx_nxt     = '0;
            ref_dy_nxt     = '0;
            strk_ctl.clear = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!en_r) begin
          state_nxt = S_EMIT0;
        end else begin
          ox_nxt    = DW'(cx_r) - DW'(org_x_r);
          oy_nxt    = DW'(cy_r) - DW'(org_y_r);
          mx_nxt    = DW'(cx_r) - DW'(prev_x_r);
          my_nxt    = DW'(cy_r) - DW'(prev_y_r);
          state_nxt = S_SQ0;
        end
      end

      // squared distance and squared limit
      S_SQ0: state_nxt = S_SQ1;
      S_SQ1: begin
        sum_nxt   = SUM_W'(prod_r);
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        sum_nxt   = sum_r + SUM_W'(prod_r);
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        state_nxt = S_FIN;
        if (!stroking_r) begin
          // seeking: offset beyond threshold with a clear dominant axis
          if (EW'(sum_r) > EW'(prod_r)) begin
            if (ax > ay && ax4 > thr3) begin
              strk_ctl.rec = 1'b1;
              strk_ctl.dir = ox_r[DW-1] ? DIR_LEFT : DIR_RIGHT;
            end else if (ay > ax && ay4 > thr3) begin
              strk_ctl.rec = 1'b1;
              strk_ctl.dir = oy_r[DW-1] ? DIR_DOWN : DIR_UP;
            end
            if (strk_ctl.rec) begin
              org_x_nxt    = cx_r;
              org_y_nxt    = cy_r;
              ref_dx_nxt   = ox_r;
              ref_dy_nxt   = oy_r;
              stroking_nxt = 1'b1;
            end
          end
        end else begin
          // stroking: stop rearms, fast motion checks for a turn
          if (EW'(sum_r) < EW'(prod_r)) begin
            org_x_nxt    = cx_r;
            org_y_nxt    = cy_r;
            stroking_nxt = 1'b0;
          end else if (EW'(sum_r) > (EW'(prod_r) << 2)) begin
            state_nxt = S_TURN0;
          end
        end
      end

      // load turn vectors; a zero vector points straight up
      S_TURN0: begin
        umx_nxt   = ax;
        umy_nxt   = (ox_r == '0 && oy_r == '0) ? DW'(1) : ay;
        sux_nxt   = ox_r[DW-1];
        suy_nxt   = oy_r[DW-1];
        vmx_nxt   = f_mag(ref_dx_r);
        vmy_nxt   = (ref_dx_r == '0 && ref_dy_r == '0) ? DW'(1) : f_mag(ref_dy_r);
        svx_nxt   = ref_dx_r[DW-1];
        svy_nxt   = ref_dy_r[DW-1];
        state_nxt = S_SHR;
      end

      // halve each vector until both components fit
      S_SHR: begin
        if (u_big) begin
          umx_nxt = umx_r >> 1;
          umy_nxt = umy_r >> 1;
        end
        if (v_big) begin
          vmx_nxt = vmx_r >> 1;
          vmy_nxt = vmy_r >> 1;
        end
        if (!u_big && !v_big) begin
          state_nxt = S_D0;
        end
      end

      // dot product, squared lengths, then the cosine compare
      S_D0: state_nxt = S_D1;
      S_D1: begin
        dot_nxt   = (sux_r ^ svx_r) ? -pterm : pterm;
        state_nxt = S_D2;
      end
      S_D2: begin
        dot_nxt   = (suy_r ^ svy_r) ? dot_r - pterm : dot_r + pterm;
        state_nxt = S_D3;
      end
      S_D3: begin
        nu_nxt    = MUL_W'(prod_r);
        state_nxt = S_D4;
      end
      S_D4: begin
        nu_nxt    = nu_r + MUL_W'(prod_r);
        state_nxt = S_D5;
      end
      S_D5: begin
        nv_nxt    = MUL_W'(prod_r);
        state_nxt = S_D6;
      end
      S_D6: begin
        nv_nxt    = nv_r + MUL_W'(prod_r);
        state_nxt = S_D7;
      end
      S_D7: begin
        sq_nxt    = prod_r;
        state_nxt = S_D8;
      end
      S_D8: begin
        if (dot_r[DOT_W-1] || dot_r == '0 ||
            ((EW'(sq_r) << 2) < (EW'(prod_r) + (EW'(prod_r) << 1)))) begin
          org_x_nxt    = cx_r;
          org_y_nxt    = cy_r;
          stroking_nxt = 1'b0;
        end
        state_nxt = S_FIN;
      end

      // close out the sample; end of gesture emits a result
      S_FIN: begin
        prev_x_nxt = cx_r;
        prev_y_nxt = cy_r;
        if (!held_r || strk_full) begin
          if (!out_busy) begin
            out_valid_nxt = 1'b1;
            act_nxt       = strk_action;
            tot_nxt       = TOTAL_W'(strk_count);
            active_nxt    = 1'b0;
            stroking_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // disabled: empty result
      S_EMIT0: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          act_nxt       = ACT_NONE;
          tot_nxt       = '0;
          active_nxt    = 1'b0;
          stroking_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= EN_RST;
      thr_r       <= THR_RST;
      stop_r      <= STOP_RST;
      active_r    <= 1'b0;
      stroking_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      thr_r       <= thr_nxt;
      stop_r      <= stop_nxt;
      active_r    <= active_nxt;
      stroking_r  <= stroking_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    held_r   <= held_nxt;
    org_x_r  <= org_x_nxt;
    org_y_r  <= org_y_nxt;
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    ref_dx_r <= ref_dx_nxt;
    ref_dy_r <= ref_dy_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    sum_r    <= sum_nxt;
    umx_r    <= umx_nxt;
    umy_r    <= umy_nxt;
    vmx_r    <= vmx_nxt;
    vmy_r    <= vmy_nxt;
    sux_r    <= sux_nxt;
    suy_r    <= suy_nxt;
    svx_r    <= svx_nxt;
    svy_r    <= svy_nxt;
    dot_r    <= dot_nxt;
    nu_r     <= nu_nxt;
    nv_r     <= nv_nxt;
    sq_r     <= sq_nxt;
    act_r    <= act_nxt;
    tot_r    <= tot_nxt;
  end

endmodule

// File: design/pgr_checker.sv
// ----------------------------------------------------------------------------
// pgr_checker
// Port-level checks on the gesture recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module pgr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pgr_pkg::ACTION_W-1:0] out_gesture_action,
  input logic [pgr_pkg::TOTAL_W-1:0]  out_stroke_total
);
  import pgr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gesture_action) &&
                               $stable(out_stroke_total))
    else $error("stalled result changed");

  // an accepted sample makes the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sample accepted without a busy cycle");

  // a result only appears out of sample processing
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // legal action codes; an empty gesture has no action
  a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gesture_action <= ACT_CLOSE) &&
                  (out_stroke_total != '0 || out_gesture_action == ACT_NONE))
    else $error("illegal result code");

endmodule

bind pointer_gesture_recognizer pgr_checker u_pgr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_gesture_action (out_gesture_action),
  .out_stroke_total   (out_stroke_total)
);

// File: verif/tb_pointer_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// tb_pointer_gesture_recognizer
// Self-checking testbench for the pointer gesture recognizer. Samples are fed
// through the valid/stall input channel while an in-bench predictor tracks the
// gesture state and queues the action each finished gesture should produce.
// Directed gestures cover coordinate extremes, three-stroke termination, the
// zero-offset turn and disabled operation; random phases then sweep the
// thresholds under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_pointer_gesture_recognizer;
  import pgr_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_SAMPLES = 105;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TOTAL_W-1:0]  total;
  } gesture_result_t;

  // DUT connections; the driven inputs are known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_pointer_x = '0;
  logic signed [15:0]    in_pointer_y = '0;
  logic                  in_button_held = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ACTION_W-1:0]   out_gesture_action;
  logic [TOTAL_W-1:0]    out_stroke_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state and shadow registers
  bit                 cfg_enable = EN_RST;
  logic [THR_W-1:0]   cfg_thr = THR_RST;
  logic [STOP_W-1:0]  cfg_stop = STOP_RST;
  bit                 act_on = 1'b0;
  bit                 is_stroking = 1'b0;
  logic signed [15:0] org_x = '0, org_y = '0, prv_x = '0, prv_y = '0;
  logic signed [16:0] ref_dx = '0, ref_dy = '0;
  dir_t               strokes [MAX_STROKES];
  logic [1:0]         n_strokes = '0;

  gesture_result_t pending_gestures[$];

  // Bookkeeping and idling control
  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  pointer_gesture_recognizer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pointer_x       (in_pointer_x),
    .in_pointer_y       (in_pointer_y),
    .in_button_held     (in_button_held),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_gesture_action (out_gesture_action),
    .out_stroke_total   (out_stroke_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint magn(longint d);
    return d < 0 ? -d : d;
  endfunction

  // squared length with each component clipped at 2048
  function automatic longint clip_sq(longint dx, longint dy);
    longint a, b;
    a = magn(dx);
    b = magn(dy);
    if (a > CLIP_MAX) a = CLIP_MAX;
    if (b > CLIP_MAX) b = CLIP_MAX;
    return a * a + b * b;
  endfunction

  function automatic longint halve(longint v);
    return v < 0 ? -(magn(v) >> 1) : (v >> 1);
  endfunction

  // more than 30 degrees apart; zero vectors point straight up
  function automatic bit turned_away(longint ux, longint uy, longint vx, longint vy);
    longint dot, d2, n;
    if (ux == 0 && uy == 0) uy = 1;
    if (vx == 0 && vy == 0) vy = 1;
    while (magn(ux) >= 16384 || magn(uy) >= 16384) begin
      ux = halve(ux);
      uy = halve(uy);
    end
    while (magn(vx) >= 16384 || magn(vy) >= 16384) begin
      vx = halve(vx);
      vy = halve(vy);
    end
    dot = ux * vx + uy * vy;
    if (dot <= 0) return 1'b1;
    d2 = dot * dot * 4;
    n = (ux * ux + uy * uy) * (vx * vx + vy * vy) * 3;
    return d2 < n;
  endfunction

  // a repeat of the last direction merges into it
  function automatic void add_stroke(dir_t d);
    if (n_strokes >= MAX_STROKES) return;
    if (n_strokes == 0 || strokes[n_strokes - 1] != d) begin
      strokes[n_strokes] = d;
      n_strokes++;
    end
  endfunction

  function automatic logic [ACTION_W-1:0] decode_action();
    if (n_strokes == 1) begin
      case (strokes[0])
        DIR_LEFT:  return ACT_BACK;
        DIR_RIGHT: return ACT_FORWARD;
        DIR_DOWN:  return ACT_NEW_WINDOW;
        default:   return ACT_NONE;
      endcase
    end
    if (n_strokes == 2) begin
      if (strokes[0] == DIR_UP) begin
        case (strokes[1])
          DIR_DOWN:  return ACT_RELOAD;
          DIR_RIGHT: return ACT_TOGGLE_SIZE;
          DIR_LEFT:  return ACT_PARENT;
          default:   return ACT_NONE;
        endcase
      end
      if (strokes[0] == DIR_DOWN) begin
        case (strokes[1])
          DIR_LEFT:  return ACT_ICONIFY;
          DIR_UP:    return ACT_DUPLICATE;
          DIR_RIGHT: return ACT_CLOSE;
          default:   return ACT_NONE;
        endcase
      end
      return ACT_NONE;
    end
    if (n_strokes == 3 && strokes[0] == DIR_RIGHT && strokes[1] == DIR_LEFT &&
        strokes[2] == DIR_RIGHT)
      return ACT_CLOSE;
    return ACT_NONE;
  endfunction

  function automatic void push_result(logic [ACTION_W-1:0] a, logic [TOTAL_W-1:0] n);
    gesture_result_t r;
    r.action = a;
    r.total = n;
    pending_gestures.push_back(r);
  endfunction

  // advance the gesture tracker by one accepted sample
  task automatic recognize_sample(logic signed [15:0] px, logic signed [15:0] py, bit held);
    longint cx, cy, ox, oy, mx, my, m2, t, s, ax, ay;
    bit hit;
    cx = px;
    cy = py;
    t = cfg_thr;
    s = cfg_stop;
    hit = 1'b0;
    if (!act_on) begin
      if (!held) return;
      if (!cfg_enable) begin
        push_result(ACT_NONE, 2'd0);
        return;
      end
      act_on = 1'b1;
      is_stroking = 1'b0;
      org_x = px;
      org_y = py;
      prv_x = px;
      prv_y = py;
      ref_dx = '0;
      ref_dy = '0;
      n_strokes = '0;
      return;
    end
    if (!cfg_enable) begin
      act_on = 1'b0;
      is_stroking = 1'b0;
      push_result(ACT_NONE, 2'd0);
      return;
    end

    ox = cx - org_x;
    oy = cy - org_y;
    mx = cx - prv_x;
    my = cy - prv_y;

    if (is_stroking) begin
      // stop or turn rearms seeking
      m2 = clip_sq(mx, my);
      if (m2 < s * s || (m2 > 4 * s * s && turned_away(ox, oy, ref_dx, ref_dy))) begin
        org_x = px;
        org_y = py;
        is_stroking = 1'b0;
      end
    end else if (clip_sq(ox, oy) > t * t) begin
      ax = magn(ox);
      ay = magn(oy);
      if (ax > ay && 4 * ax > 3 * t) begin
        add_stroke(ox < 0 ? DIR_LEFT : DIR_RIGHT);
        hit = 1'b1;
      end else if (ay > ax && 4 * ay > 3 * t) begin
        add_stroke(oy < 0 ? DIR_DOWN : DIR_UP);
        hit = 1'b1;
      end
      if (hit) begin
        org_x = px;
        org_y = py;
        ref_dx = ox[16:0];
        ref_dy = oy[16:0];
        is_stroking = 1'b1;
      end
    end
    prv_x = px;
    prv_y = py;

    if (!held || n_strokes == MAX_STROKES) begin
      push_result(decode_action(), n_strokes);
      act_on = 1'b0;
      is_stroking = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    gesture_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_gestures.size() == 0) begin
        report_mismatch($sformatf("unexpected result action %0d total %0d",
                                  out_gesture_action, out_stroke_total));
      end else begin
        want = pending_gestures.pop_front();
        if (out_gesture_action !== want.action)
          report_mismatch($sformatf("gesture_action %0d, expected %0d",
                                    out_gesture_action, want.action));
        if (out_stroke_total !== want.total)
          report_mismatch($sformatf("stroke_total %0d, expected %0d",
                                    out_stroke_total, want.total));
      end
    end
  end

  // Result-side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (!quiet && $urandom_range(99) < stall_pct)
      stall_left = $urandom_range(14, 1);
    out_stall <= (stall_left > 0);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_sample(int x, int y, bit held);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(13)) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_pointer_x   <= x[15:0];
    in_pointer_y   <= y[15:0];
    in_button_held <= held;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    recognize_sample(in_pointer_x, in_pointer_y, in_button_held);
    samples_sent++;
  endtask

  // stop sending, let every result drain and the sequencer settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE:    cfg_enable = val[0];
      CFG_THRESHOLD: cfg_thr = val[THR_W-1:0];
      CFG_STOP:      cfg_stop = val[STOP_W-1:0];
      default:       ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(bit en, int thr, int stop);
    drain();
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_STOP, CFG_DATA_W'(stop));
  endtask

  task automatic pick_idling();
    case ($urandom_range(3))
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 10; stall_pct = 10; end
      2:       begin gap_pct = 35; stall_pct = 25; end
      default: begin gap_pct = 60; stall_pct = 50; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------------
  // raw samples over the full coordinate range, closed by a release
  task automatic random_noise(int count);
    int x, y;
    for (int i = 0; i < count; i++) begin
      x = int'($urandom());
      y = int'($urandom());
      if ($urandom_range(7) == 0) x = $urandom_range(1) ? 32767 : -32768;
      if ($urandom_range(7) == 0) y = $urandom_range(1) ? 32767 : -32768;
      send_sample(x, y, (i == count - 1) ? 1'b0 : 1'($urandom_range(1)));
    end
  endtask

  // press, a sequence of straight strokes with jitter and pauses, release
  task automatic random_gesture();
    dir_t seq[$];
    int px, py, ux, uy, step, nsteps, target, jit, thr, stop;
    thr = cfg_thr;
    stop = cfg_stop;
    case ($urandom_range(14))
      0:  seq.push_back(DIR_LEFT);
      1:  seq.push_back(DIR_RIGHT);
      2:  seq.push_back(DIR_DOWN);
      3:  seq.push_back(DIR_UP);
      4:  begin seq.push_back(DIR_UP);   seq.push_back(DIR_DOWN);  end
      5:  begin seq.push_back(DIR_UP);   seq.push_back(DIR_RIGHT); end
      6:  begin seq.push_back(DIR_UP);   seq.push_back(DIR_LEFT);  end
      7:  begin seq.push_back(DIR_DOWN); seq.push_back(DIR_LEFT);  end
      8:  begin seq.push_back(DIR_DOWN); seq.push_back(DIR_UP);    end
      9:  begin seq.push_back(DIR_DOWN); seq.push_back(DIR_RIGHT); end
      10: begin
        seq.push_back(DIR_RIGHT);
        seq.push_back(DIR_LEFT);
        seq.push_back(DIR_RIGHT);
      end
      default: repeat ($urandom_range(4, 1)) seq.push_back(dir_t'($urandom_range(3)));
    endcase
    pick_idling();
    px = int'($urandom_range(48000)) - 24000;
    py = int'($urandom_range(48000)) - 24000;
    send_sample(px, py, 1'b1);
    foreach (seq[i]) begin
      case (seq[i])
        DIR_LEFT:  begin ux = -1; uy = 0;  end
        DIR_RIGHT: begin ux = 1;  uy = 0;  end
        DIR_UP:    begin ux = 0;  uy = 1;  end
        default:   begin ux = 0;  uy = -1; end
      endcase
      step = thr / int'($urandom_range(6, 2));
      if (step < 2 * stop + 1) step = 2 * stop + 1;
      target = thr + thr / 4 + 1 + int'($urandom_range(thr / 4));
      nsteps = target / step + 2;
      // a broken gesture now and then: last stroke cut short
      if (i == seq.size() - 1 && $urandom_range(7) == 0) nsteps = nsteps / 2;
      for (int k = 0; k < nsteps; k++) begin
        jit = int'($urandom_range(2 * (step / 4))) - step / 4;
        px += ux * step + uy * jit;
        py += uy * step + ux * jit;
        send_sample(px, py, 1'b1);
        if ($urandom_range(99) < 15) send_sample(px, py, 1'b1);
      end
    end
    if ($urandom_range(3) == 0) begin
      px += int'($urandom_range(2 * thr)) - thr;
      py += int'($urandom_range(2 * thr)) - thr;
    end
    send_sample(px, py, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // releases while idle are ignored
  task automatic test_idle_release();
    send_sample(5, -7, 1'b0);
    send_sample(-32768, 32767, 1'b0);
  endtask

  // full-range jumps: equal axes, clipped distances, turn vector shrinking
  task automatic test_extreme_coords();
    send_sample(-32768, 32767, 1'b1);
    send_sample(32767, -32768, 1'b1);
    send_sample(32767, 32767, 1'b1);
    send_sample(-32768, -32768, 1'b1);
    send_sample(-32768, -32768, 1'b0);
  endtask

  // one stroke then a stop on the release sample
  task automatic test_single_stroke();
    send_sample(0, 0, 1'b1);
    send_sample(-20, 0, 1'b1);
    send_sample(-20, 0, 1'b0);
  endtask

  // right, left, right ends the gesture with the button still held
  task automatic test_three_strokes();
    send_sample(100, 100, 1'b1);
    send_sample(120, 100, 1'b1);
    send_sample(100, 100, 1'b1);
    send_sample(80, 100, 1'b1);
    send_sample(100, 100, 1'b1);
    send_sample(120, 100, 1'b1);
  endtask

  // back at the stroke origin: zero offset counts as pointing up
  task automatic test_zero_offset_turn();
    send_sample(0, 0, 1'b1);
    send_sample(0, -20, 1'b1);
    send_sample(0, -25, 1'b1);
    send_sample(0, -20, 1'b1);
    send_sample(0, -20, 1'b0);
  endtask

  // disabling mid-gesture and while idle
  task automatic test_disabled();
    send_sample(100, 100, 1'b1);
    drain();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1'b0));
    send_sample(150, 100, 1'b1);
    send_sample(0, 0, 1'b1);
    send_sample(0, 0, 1'b0);
    pick_idling();
    random_noise(6);
    drain();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1'b1));
  endtask

  task automatic test_random_gestures();
    int stop_at;
    int en_tab[8]   = '{1, 1, 1, 1, 1, 1, 1, 1};
    int thr_tab[8]  = '{16, 1, 1023, 1023, 1, 200, 40, 16};
    int stop_tab[8] = '{2, 0, 255, 0, 255, 10, 5, 2};
    for (int p = 0; p < 8; p++) begin
      apply_settings(1'(en_tab[p]), thr_tab[p], stop_tab[p]);
      // final phase runs without any idling
      if (p == 7) quiet = 1'b1;
      stop_at = samples_sent + PHASE_SAMPLES;
      while (samples_sent < stop_at) begin
        if ($urandom_range(9) == 0) begin
          pick_idling();
          random_noise($urandom_range(6, 1));
        end else begin
          random_gesture();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_idle_release();
    test_extreme_coords();
    test_single_stroke();
    test_three_strokes();
    test_zero_offset_turn();
    test_disabled();
    test_random_gestures();

    drain();
    while (pending_gestures.size() != 0) begin
      report_mismatch("expected result never arrived");
      void'(pending_gestures.pop_front());
    end

    $display("covered %0d samples, %0d gestures finished, %0d register writes",
             samples_sent, results_checked, cfg_writes);
    $display("thresholds 1..1023, stop distance 0..255, enable on and off, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb_pointer_gesture_recognizer: PASS");
    end else begin
      $display("tb_pointer_gesture_recognizer: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(4 * 400000);
    $display("watchdog expired: handshake hung");
    $display("tb_pointer_gesture_recognizer: FAIL");
    $finish;
  end

endmodule

// File: files.f
design/pgr_pkg.sv
design/pgr_mul.sv
design/pgr_strokes.sv
design/pointer_gesture_recognizer.sv
design/pgr_checker.sv
verif/tb_pointer_gesture_recognizer.sv
